/* sv/sfcan_pkg.sv */
`default_nettype none

package sfcan_pkg;

    localparam int MAX_FRAME_BYTES = 8;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 2);
    localparam int IDX_W           = $clog2(MAX_FRAME_BYTES);

    localparam int BYTE_W    = 8;
    localparam int PAYLOAD_W = 64;
    localparam int LEN_W     = 3;
    localparam int LEN_MIN   = 2;
    localparam int LEN_MAX   = 5;
    localparam int TRAILER   = 3;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_HEADER = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_TAIL   = REG_IDX_W'(1);

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAF;
    localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'hFA;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LEN_ERR  = 2'd1,
        ST_TAIL_ERR = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [BYTE_W-1:0] tail_byte;
    } t_cfg;

endpackage

`default_nettype wire

/* sv/serial_frame_to_can_payload.sv */
// Serial frame to CAN payload parser.
// Input channel: one received serial byte per transaction (i_in_valid, o_in_stall,
// i_rx_byte). Frames are header, length L (2..5), L data bytes, tail.
// Output channel: one transaction per finished frame or error (o_out_valid,
// i_out_stall, o_status, o_payload, o_data_length). Status 0 is a good frame
// with the header and data bytes packed from bit 0 up and zero padded; status 1
// is a length error, status 2 a tail error, both with zero payload and length.
// A wrong first byte or a header mismatch drops the partial frame silently.
// Header and tail values come from the APB registers at 0x0 and 0x4.
// A byte lands in the input register when it is accepted; its result is registered
// in the output register when the byte advances, which a waiting result can hold.
// Throughput: one byte per cycle unless a stalled result holds the input; the
// input register and output register each hold one transaction, so a new
// byte is taken while a result waits. While the receiver stalls and a result
// waits, bytes that produce no result keep flowing; a byte that would produce
// a second result holds the input. Reset clears the byte count, both valid
// flags and restores header 0xAF and tail 0xFA.
`default_nettype none

module serial_frame_to_can_payload (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [7:0]                           i_rx_byte,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic      [1:0]                           o_status,
    output logic      [63:0]                          o_payload,
    output logic      [2:0]                           o_data_length,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [sfcan_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [sfcan_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [sfcan_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                      pready
);

    sfcan_pkg::t_cfg cfg;

    sfcan_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic                              r_in_valid;
    logic [sfcan_pkg::BYTE_W-1:0]      r_in_byte;
    logic [sfcan_pkg::CNT_W-1:0]       r_count;
    logic [sfcan_pkg::BYTE_W-1:0]      r_buf [sfcan_pkg::MAX_FRAME_BYTES];
    logic                              r_out_valid;
    sfcan_pkg::t_status                r_status;
    logic [sfcan_pkg::PAYLOAD_W-1:0]   r_payload;
    logic [sfcan_pkg::LEN_W-1:0]       r_length;

    logic [sfcan_pkg::CNT_W-1:0]       n_count;
    logic                              n_has_res;
    sfcan_pkg::t_status                n_status;
    logic [sfcan_pkg::PAYLOAD_W-1:0]   n_payload;
    logic [sfcan_pkg::LEN_W-1:0]       n_length;

    logic [sfcan_pkg::BYTE_W-1:0]      first_byte;
    logic [sfcan_pkg::BYTE_W-1:0]      len_byte;
    logic [sfcan_pkg::LEN_W-1:0]       len3;
    logic [sfcan_pkg::CNT_W-1:0]       cnt_inc;
    logic [sfcan_pkg::CNT_W-1:0]       frame_end;
    logic [sfcan_pkg::PAYLOAD_W-1:0]   good_payload;
    logic                              len_bad;
    logic                              advance;
    logic                              in_accept;

    assign advance    = r_in_valid && (!n_has_res || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign first_byte = (r_count == '0) ? r_in_byte : r_buf[0];
    assign len_byte   = r_buf[1];
    assign len3       = len_byte[sfcan_pkg::LEN_W-1:0];
    assign len_bad    = (len_byte < sfcan_pkg::BYTE_W'(sfcan_pkg::LEN_MIN))
                     || (len_byte > sfcan_pkg::BYTE_W'(sfcan_pkg::LEN_MAX));
    assign cnt_inc    = r_count + 1'b1;
    assign frame_end  = sfcan_pkg::CNT_W'(len3) + sfcan_pkg::CNT_W'(sfcan_pkg::TRAILER);

    always_comb begin
        good_payload = '0;
        good_payload[sfcan_pkg::BYTE_W-1:0] = cfg.header_byte;
        for (int k = 1; k <= sfcan_pkg::LEN_MAX; k++) begin
            if (sfcan_pkg::LEN_W'(k) <= len3) begin
                good_payload[k*sfcan_pkg::BYTE_W +: sfcan_pkg::BYTE_W] =
                    r_buf[sfcan_pkg::IDX_W'(k + 1)];
            end
        end
    end

    always_comb begin
        n_count   = cnt_inc;
        n_has_res = 1'b0;
        n_status  = sfcan_pkg::ST_OK;
        n_payload = '0;
        n_length  = '0;
        priority if (first_byte != cfg.header_byte) begin
            n_count = '0;
        end else if (cnt_inc > sfcan_pkg::CNT_W'(sfcan_pkg::MAX_FRAME_BYTES)) begin
            n_count   = '0;
            n_has_res = 1'b1;
            n_status  = sfcan_pkg::ST_LEN_ERR;
        end else if (cnt_inc <= sfcan_pkg::CNT_W'(2)) begin
            n_count = cnt_inc;
        end else if (len_bad) begin
            n_count   = '0;
            n_has_res = 1'b1;
            n_status  = sfcan_pkg::ST_LEN_ERR;
        end else if (cnt_inc < frame_end) begin
            n_count = cnt_inc;
        end else if (r_in_byte != cfg.tail_byte) begin
            n_count   = '0;
            n_has_res = 1'b1;
            n_status  = sfcan_pkg::ST_TAIL_ERR;
        end else begin
            n_count   = '0;
            n_has_res = 1'b1;
            n_status  = sfcan_pkg::ST_OK;
            n_payload = good_payload;
            n_length  = len3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (advance) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && (r_count < sfcan_pkg::CNT_W'(sfcan_pkg::MAX_FRAME_BYTES))) begin
            r_buf[r_count[sfcan_pkg::IDX_W-1:0]] <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && n_has_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_has_res) begin
            r_status  <= n_status;
            r_payload <= n_payload;
            r_length  <= n_length;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_payload     = r_payload;
    assign o_data_length = r_length;

endmodule

`default_nettype wire

/* sv/sfcan_apb_regs.sv */
`default_nettype none

module sfcan_apb_regs (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [sfcan_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [sfcan_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [sfcan_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                      pready,
    output sfcan_pkg::t_cfg                           o_cfg
);

    logic [sfcan_pkg::BYTE_W-1:0]    r_header;
    logic [sfcan_pkg::BYTE_W-1:0]    r_tail;
    logic [sfcan_pkg::REG_IDX_W-1:0] reg_sel;
    logic                            wr_en;

    assign reg_sel = paddr[sfcan_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= sfcan_pkg::HEADER_RESET;
            r_tail   <= sfcan_pkg::TAIL_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                sfcan_pkg::REG_HEADER: r_header <= pwdata[sfcan_pkg::BYTE_W-1:0];
                sfcan_pkg::REG_TAIL:   r_tail   <= pwdata[sfcan_pkg::BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            sfcan_pkg::REG_HEADER: prdata[sfcan_pkg::BYTE_W-1:0] = r_header;
            sfcan_pkg::REG_TAIL:   prdata[sfcan_pkg::BYTE_W-1:0] = r_tail;
            default:               prdata = '0;
        endcase
    end

    assign o_cfg.header_byte = r_header;
    assign o_cfg.tail_byte   = r_tail;

endmodule

`default_nettype wire

/* sv/sfcan_checker.sv */
`default_nettype none

module sfcan_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_status,
    input wire logic [63:0] o_payload,
    input wire logic [2:0]  o_data_length
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_payload)
            && $stable(o_status) && $stable(o_data_length))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != sfcan_pkg::ST_OK)
            |-> (o_payload == '0) && (o_data_length == '0))
        else $error("error result carries data");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == sfcan_pkg::ST_OK)
            |-> (o_data_length >= 3'd2) && (o_data_length <= 3'd5))
        else $error("accepted frame length out of range");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == sfcan_pkg::ST_OK) || (o_status == sfcan_pkg::ST_LEN_ERR)
            || (o_status == sfcan_pkg::ST_TAIL_ERR))
        else $error("unknown status code");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == sfcan_pkg::ST_OK) |-> (o_payload[63:48] == '0))
        else $error("payload padding not zero");

endmodule

bind serial_frame_to_can_payload sfcan_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_payload     (o_payload),
    .o_data_length (o_data_length)
);

`default_nettype wire

/* test/tb.sv */
typedef struct {
    sfcan_pkg::t_status              status;
    logic [sfcan_pkg::PAYLOAD_W-1:0] payload;
    logic [sfcan_pkg::LEN_W-1:0]     length;
} t_frame_result;

class frame_predictor;
    logic [sfcan_pkg::BYTE_W-1:0] header;
    logic [sfcan_pkg::BYTE_W-1:0] tail;
    logic [sfcan_pkg::BYTE_W-1:0] buffer [sfcan_pkg::MAX_FRAME_BYTES];
    int unsigned                  count;
    t_frame_result                results_due [$];
    int                           errors;

    function new();
        header = sfcan_pkg::HEADER_RESET;
        tail   = sfcan_pkg::TAIL_RESET;
        count  = 0;
        errors = 0;
        foreach (buffer[i]) buffer[i] = '0;
    endfunction

    function void set_register(logic [sfcan_pkg::REG_IDX_W-1:0] idx,
                               logic [sfcan_pkg::BYTE_W-1:0] value);
        if (idx == sfcan_pkg::REG_HEADER) begin
            header = value;
        end else if (idx == sfcan_pkg::REG_TAIL) begin
            tail = value;
        end
    endfunction

    function int pending();
        return results_due.size();
    endfunction

    function void finish_frame(sfcan_pkg::t_status st,
                               logic [sfcan_pkg::PAYLOAD_W-1:0] pay, int len);
        t_frame_result r;
        r.status  = st;
        r.payload = pay;
        r.length  = sfcan_pkg::LEN_W'(len);
        results_due.push_back(r);
        count = 0;
    endfunction

    function void take_byte(logic [sfcan_pkg::BYTE_W-1:0] b);
        int                              len;
        logic [sfcan_pkg::PAYLOAD_W-1:0] pay;
        if (count < sfcan_pkg::MAX_FRAME_BYTES) buffer[count] = b;
        count++;
        if (buffer[0] != header) begin
            count = 0;
            return;
        end
        if (count > sfcan_pkg::MAX_FRAME_BYTES) begin
            finish_frame(sfcan_pkg::ST_LEN_ERR, '0, 0);
            return;
        end
        if (count <= 2) return;
        len = int'(buffer[1]);
        if (len < sfcan_pkg::LEN_MIN || len > sfcan_pkg::LEN_MAX) begin
            finish_frame(sfcan_pkg::ST_LEN_ERR, '0, 0);
            return;
        end
        if (count < len + sfcan_pkg::TRAILER) return;
        if (buffer[len + 2] != tail) begin
            finish_frame(sfcan_pkg::ST_TAIL_ERR, '0, 0);
            return;
        end
        pay = sfcan_pkg::PAYLOAD_W'(header);
        for (int i = 0; i < len; i++) begin
            pay |= sfcan_pkg::PAYLOAD_W'(buffer[i + 2]) << (8 * (i + 1));
        end
        finish_frame(sfcan_pkg::ST_OK, pay, len);
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_frame(logic [1:0] st, logic [sfcan_pkg::PAYLOAD_W-1:0] pay,
                     logic [sfcan_pkg::LEN_W-1:0] len);
        t_frame_result r;
        if (results_due.size() == 0) begin
            report($sformatf("unexpected result status %0d payload %h", st, pay));
            return;
        end
        r = results_due.pop_front();
        if (st !== r.status)
            report($sformatf("status %0d, expected %0d", st, r.status));
        if (pay !== r.payload)
            report($sformatf("payload %h, expected %h", pay, r.payload));
        if (len !== r.length)
            report($sformatf("data_length %0d, expected %0d", len, r.length));
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                             i_clk;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    logic                             o_in_stall;
    logic [7:0]                       i_rx_byte   = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic [1:0]                       o_status;
    logic [63:0]                      o_payload;
    logic [2:0]                       o_data_length;
    logic                             psel        = 1'b0;
    logic                             penable     = 1'b0;
    logic                             pwrite      = 1'b0;
    logic [sfcan_pkg::APB_ADDR_W-1:0] paddr       = '0;
    logic [sfcan_pkg::APB_DATA_W-1:0] pwdata      = '0;
    logic [sfcan_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    frame_predictor               sb;
    int                           send_pct  = 0;
    int                           stall_pct = 0;
    logic [sfcan_pkg::BYTE_W-1:0] byte_q [$];

    serial_frame_to_can_payload dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_payload     (o_payload),
        .o_data_length (o_data_length),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            sb.check_frame(o_status, o_payload, o_data_length);
        end
    end

    task automatic send_byte(input logic [sfcan_pkg::BYTE_W-1:0] b);
        while (send_pct != 0 && $urandom_range(99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.take_byte(b);
    endtask

    task automatic send_queue(output int n);
        n = byte_q.size();
        while (byte_q.size() != 0) send_byte(byte_q.pop_front());
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [sfcan_pkg::REG_IDX_W-1:0] idx,
                             input logic [sfcan_pkg::BYTE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sfcan_pkg::APB_ADDR_W'({idx, 2'b00});
        pwdata  <= sfcan_pkg::APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
        @(posedge i_clk);
    endtask

    task automatic queue_frame();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 92) byte_q.push_back(sb.header);
        if (r < 75) begin
            len = $urandom_range(sfcan_pkg::LEN_MAX, sfcan_pkg::LEN_MIN);
            byte_q.push_back(sfcan_pkg::BYTE_W'(len));
            for (int i = 0; i < len; i++)
                byte_q.push_back(sfcan_pkg::BYTE_W'($urandom_range(255)));
            byte_q.push_back(r < 65 ? sb.tail : sfcan_pkg::BYTE_W'($urandom_range(255)));
        end else if (r < 85) begin
            len = $urandom_range(1) ? $urandom_range(sfcan_pkg::LEN_MIN - 1) :
                                      $urandom_range(255, sfcan_pkg::LEN_MAX + 1);
            byte_q.push_back(sfcan_pkg::BYTE_W'(len));
            byte_q.push_back(sfcan_pkg::BYTE_W'($urandom_range(255)));
        end else if (r < 92) begin
            // truncated frame, the next bytes land inside it
            len = $urandom_range(sfcan_pkg::LEN_MAX, sfcan_pkg::LEN_MIN);
            byte_q.push_back(sfcan_pkg::BYTE_W'(len));
            for (int i = 0; i < $urandom_range(len); i++)
                byte_q.push_back(sfcan_pkg::BYTE_W'($urandom_range(255)));
        end else begin
            byte_q.push_back(sfcan_pkg::BYTE_W'($urandom_range(255)));
        end
    endtask

    logic [sfcan_pkg::BYTE_W-1:0] hdr_set  [8];
    logic [sfcan_pkg::BYTE_W-1:0] tail_set [8];
    int                           sent;
    int                           n;

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        byte_q = '{8'h00,
                   sfcan_pkg::HEADER_RESET, 8'h02, 8'h00, 8'hFF, sfcan_pkg::TAIL_RESET,
                   sfcan_pkg::HEADER_RESET, 8'h00, 8'h55,
                   sfcan_pkg::HEADER_RESET, 8'hFF, 8'hAA,
                   sfcan_pkg::HEADER_RESET, 8'h05, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h00,
                   8'h00,
                   sfcan_pkg::HEADER_RESET, 8'h03, 8'hFF, 8'hFF, 8'hFF,
                   sfcan_pkg::TAIL_RESET};
        send_queue(n);

        hdr_set  = '{8'h00, 8'hFF, 8'h5A, 8'h02, sfcan_pkg::HEADER_RESET, 8'h00, 8'hFF,
                     sfcan_pkg::HEADER_RESET};
        tail_set = '{8'hFF, 8'h00, 8'h5A, 8'h02, sfcan_pkg::TAIL_RESET, 8'h00, 8'hFF,
                     sfcan_pkg::TAIL_RESET};
        hdr_set[5]  = sfcan_pkg::BYTE_W'($urandom_range(255));
        tail_set[5] = sfcan_pkg::BYTE_W'($urandom_range(255));

        for (int p = 0; p < 8; p++) begin
            // leave a partial frame behind so the header change hits it mid-frame
            if ($urandom_range(1)) begin
                byte_q.push_back(sb.header);
                byte_q.push_back(sfcan_pkg::BYTE_W'(
                    $urandom_range(sfcan_pkg::LEN_MAX, sfcan_pkg::LEN_MIN)));
                send_queue(n);
            end
            drain();
            apb_write(sfcan_pkg::REG_HEADER, hdr_set[p]);
            apb_write(sfcan_pkg::REG_TAIL, tail_set[p]);
            case (p % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 73; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 73; end
                default: begin send_pct = 23; stall_pct = 23; end
            endcase
            sent = 0;
            while (sent < 100) begin
                queue_frame();
                send_queue(n);
                sent += n;
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

/* sim.f */
sv/sfcan_pkg.sv
sv/sfcan_apb_regs.sv
sv/serial_frame_to_can_payload.sv
sv/sfcan_checker.sv
test/tb.sv
